// File: rtl/dqb_pkg.sv
`timescale 1ns / 1ps

package dqb_pkg;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam int HDR_LEN  = 12;
    localparam int TAIL_LEN = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN,
        ST_CHAR,
        ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        SRC_HDR,
        SRC_LEN,
        SRC_CHAR,
        SRC_TAIL
    } src_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_out;
        src_t src;
        logic ram_re;
        logic clear_label;
        logic run_end;
        logic packet_end;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic first;
        logic in_flush;
        logic out_free;
        logic flush;
        logic tail;
        logic count_zero;
        logic last_char;
    } sts_t;

    // header: id low, id high, flags 0x0100, qdcount 1, other counts 0
    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
        logic [7:0] b;
        begin
            case (idx)
                4'd0:    b = id[7:0];
                4'd1:    b = id[15:8];
                4'd2:    b = 8'h01;
                4'd5:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    // root terminator, type A, class IN
    function automatic logic [7:0] tail_byte(input logic [2:0] idx);
        logic [7:0] b;
        begin
            case (idx)
                3'd2:    b = 8'h01;
                3'd4:    b = 8'h01;
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

endpackage

// File: rtl/dqb_ram.sv
`timescale 1ns / 1ps

module dqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dqb_ctrl.sv
`timescale 1ns / 1ps

module dqb_ctrl
    import dqb_pkg::*;
#(
    parameter int IW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sts_t          sts,
    output cmd_t          cmd,
    output logic [IW-1:0] idx
);

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic hdr_done;
    logic tail_done;

    assign hdr_done  = (idx_reg == IW'(HDR_LEN - 1));
    assign tail_done = (idx_reg == IW'(TAIL_LEN - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    if (sts.first)
                        state_next = ST_HDR;
                    else if (sts.in_flush)
                        state_next = ST_LEN;
                end
            end
            ST_HDR:
            begin
                if (sts.out_free && hdr_done)
                    state_next = sts.flush ? ST_LEN : ST_IDLE;
            end
            ST_LEN:
            begin
                if (sts.out_free)
                begin
                    if (!sts.count_zero)
                        state_next = ST_CHAR;
                    else
                        state_next = sts.tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (sts.out_free && sts.last_char)
                    state_next = sts.tail ? ST_TAIL : ST_IDLE;
            end
            ST_TAIL:
            begin
                if (sts.out_free && tail_done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        cmd.src = SRC_HDR;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
            end
            ST_HDR:
            begin
                cmd.load_out = sts.out_free;
                cmd.src      = SRC_HDR;
                cmd.run_end  = hdr_done && !sts.flush;
            end
            ST_LEN:
            begin
                cmd.load_out    = sts.out_free;
                cmd.src         = SRC_LEN;
                cmd.ram_re      = sts.out_free && !sts.count_zero;
                cmd.clear_label = sts.out_free && sts.count_zero;
                cmd.run_end     = sts.count_zero && !sts.tail;
            end
            ST_CHAR:
            begin
                cmd.load_out    = sts.out_free;
                cmd.src         = SRC_CHAR;
                cmd.ram_re      = sts.out_free && !sts.last_char;
                cmd.clear_label = sts.out_free && sts.last_char;
                cmd.run_end     = sts.last_char && !sts.tail;
            end
            ST_TAIL:
            begin
                cmd.load_out   = sts.out_free;
                cmd.src        = SRC_TAIL;
                cmd.run_end    = tail_done;
                cmd.packet_end = tail_done;
            end
            default: cmd = '0;
        endcase
    end

    // byte index within the current section
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load_out)
        begin
            if (state_next != state_reg)
                idx_next = '0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

// File: rtl/dqb_dp.sv
`timescale 1ns / 1ps

module dqb_dp
    import dqb_pkg::*;
#(
    parameter int MAX_LABEL = 32,
    parameter int IW        = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    in_char,
    input  logic [15:0]   in_id,
    input  logic          in_last,
    input  cmd_t          cmd,
    input  logic [IW-1:0] idx,
    output sts_t          sts,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [7:0]    out_byte,
    output logic          out_run_end,
    output logic          out_packet_end,
    output logic          out_overflow
);

    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          in_name_reg, in_name_next;
    logic          flush_reg, tail_reg;
    logic [15:0]   id_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          run_end_reg, packet_end_reg, out_ovf_reg;

    logic          accept;
    logic          in_dot;
    logic          full;
    logic [CW-1:0] base_count;
    logic          base_ovf;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    byte_mux;
    logic          ovf_mux;

    assign accept     = cmd.accept && in_valid;
    assign in_dot     = (in_char == DOT_CHAR);
    // a new name starts with an empty label
    assign base_count = in_name_reg ? count_reg : '0;
    assign base_ovf   = in_name_reg ? ovf_reg : 1'b0;
    assign full       = (base_count >= CW'(MAX_LABEL));
    assign ram_we     = accept && !in_dot && !full;
    assign ram_raddr  = (cmd.src == SRC_LEN) ? '0 : AW'(idx + 1'b1);

    dqb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(base_count)),
        .wdata (in_char),
        .re    (cmd.ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        in_name_next = in_name_reg;
        if (accept)
        begin
            in_name_next = !in_last;
            count_next   = base_count;
            ovf_next     = base_ovf;
            if (!in_dot)
            begin
                if (full)
                    ovf_next = 1'b1;
                else
                    count_next = base_count + 1'b1;
            end
        end
        else if (cmd.clear_label)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.src)
            SRC_HDR:  byte_mux = hdr_byte(idx[3:0], id_reg);
            SRC_LEN:  byte_mux = 8'(count_reg);
            SRC_CHAR: byte_mux = ram_rdata;
            SRC_TAIL: byte_mux = tail_byte(idx[2:0]);
            default:  byte_mux = 8'h00;
        endcase
        ovf_mux = ovf_reg && (cmd.src == SRC_LEN || cmd.src == SRC_CHAR);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            in_name_reg   <= 1'b0;
            flush_reg     <= 1'b0;
            tail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            in_name_reg   <= in_name_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                flush_reg <= in_dot || in_last;
                tail_reg  <= in_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg <= in_id;
        end
        if (cmd.load_out)
        begin
            out_byte_reg   <= byte_mux;
            run_end_reg    <= cmd.run_end;
            packet_end_reg <= cmd.packet_end;
            out_ovf_reg    <= ovf_mux;
        end
    end

    assign sts.in_valid   = in_valid;
    assign sts.first      = !in_name_reg;
    assign sts.in_flush   = in_dot || in_last;
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.flush      = flush_reg;
    assign sts.tail       = tail_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.last_char  = (({1'b0, idx} + 1'b1) == (IW + 1)'(count_reg));

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign out_run_end    = run_end_reg;
    assign out_packet_end = packet_end_reg;
    assign out_overflow   = out_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LABEL))
        else $error("label count beyond store capacity");

    a_pkt_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && packet_end_reg |-> run_end_reg)
        else $error("packet end without run end");

    a_ovf_label_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && (cmd.src == SRC_HDR || cmd.src == SRC_TAIL) |=> !out_ovf_reg)
        else $error("overflow flag on a header or tail byte");

endmodule

// File: rtl/dns_query_builder.sv
`timescale 1ns / 1ps

// channel | dir | tdata                                    | tlast      | tuser
// s_axis  | in  | [7:0] name_char, [23:8] query_id          | name_end   | -
// m_axis  | out | [7:0] out_byte, [8] run_end, [15:9] zero  | packet_end | label_overflow
//
// a character that gives no byte is taken and the block stays idle; a character that gives
// bytes is taken, then loads them while the sink takes them: 12 header bytes on the first
// character, 1 + label length bytes per flushed label, 5 closing bytes after the last one.
// the label store read is issued one byte ahead of the single output register that it feeds.
// no new character is taken until the bytes it causes are all in the output register.
// rst_n is asynchronous; the label store has no clearing pass, only its fill count resets.
// a stalled sink holds the output word and the whole sequence behind it.

module dns_query_builder
    import dqb_pkg::*;
#(
    parameter int MAX_LABEL = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // name_char, query_id
    input  logic        s_axis_tlast,   // name_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, run_end, zero fill
    output logic        m_axis_tlast,   // packet_end
    output logic        m_axis_tuser    // label_overflow
);

    // index covers the header count and the longest label
    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam int IW = (CW > 4) ? CW : 4;

    cmd_t          cmd;
    sts_t          sts;
    logic [IW-1:0] idx;
    logic [7:0]    out_byte;
    logic          run_end;

    dqb_ctrl #(
        .IW (IW)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd),
        .idx   (idx)
    );

    dqb_dp #(
        .MAX_LABEL (MAX_LABEL),
        .IW        (IW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_char        (s_axis_tdata[7:0]),
        .in_id          (s_axis_tdata[23:8]),
        .in_last        (s_axis_tlast),
        .cmd            (cmd),
        .idx            (idx),
        .sts            (sts),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_byte       (out_byte),
        .out_run_end    (run_end),
        .out_packet_end (m_axis_tlast),
        .out_overflow   (m_axis_tuser)
    );

    // the controller takes a character only from its idle state
    assign s_axis_tready = cmd.accept;
    assign m_axis_tdata  = {7'b0, run_end, out_byte};

endmodule

// File: bench/query_packet_monitor.sv
`timescale 1ns / 1ps

module query_packet_monitor
    import dqb_pkg::*;
#(
    parameter int MAX_LABEL = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // name_char, query_id
    input  logic        s_axis_tlast,   // name_end

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // out_byte, run_end, zero fill
    input  logic        m_axis_tlast,   // packet_end
    input  logic        m_axis_tuser,   // label_overflow

    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       packet_end;
        logic       lost;
    } query_byte_t;

    query_byte_t query_bytes_due[$];

    logic [7:0] label_buf [MAX_LABEL];
    int         label_len  = 0;
    logic       label_lost = 1'b0;
    logic       name_open  = 1'b0;
    int         byte_idx   = 0;

    function automatic query_byte_t mk_byte(input logic [7:0] b, input logic lost);
        query_byte_t w;
        w.data       = b;
        w.run_end    = 1'b0;
        w.packet_end = 1'b0;
        w.lost       = lost;
        return w;
    endfunction

    // length byte then the held characters, all tagged with the label's loss flag
    function automatic void flush_label();
        query_bytes_due.push_back(mk_byte(8'(label_len), label_lost));
        for (int i = 0; i < label_len; i++)
            query_bytes_due.push_back(mk_byte(label_buf[i], label_lost));
        label_len  = 0;
        label_lost = 1'b0;
    endfunction

    function automatic void predict_query_bytes(input logic [7:0] ch, input logic [15:0] id,
                                                input logic name_end);
        int first;
        first = query_bytes_due.size();
        if (!name_open)
        begin
            label_len  = 0;
            label_lost = 1'b0;
            query_bytes_due.push_back(mk_byte(id[7:0], 1'b0));
            query_bytes_due.push_back(mk_byte(id[15:8], 1'b0));
            query_bytes_due.push_back(mk_byte(8'h01, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h00, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h00, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h01, 1'b0));
            while (query_bytes_due.size() - first < HDR_LEN)
                query_bytes_due.push_back(mk_byte(8'h00, 1'b0));
            name_open = 1'b1;
        end
        if (ch == DOT_CHAR)
            flush_label();
        else
        begin
            if (label_len < MAX_LABEL)
            begin
                label_buf[label_len] = ch;
                label_len++;
            end
            else
                label_lost = 1'b1;
            if (name_end)
                flush_label();
        end
        if (name_end)
        begin
            query_bytes_due.push_back(mk_byte(8'h00, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h00, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h01, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h00, 1'b0));
            query_bytes_due.push_back(mk_byte(8'h01, 1'b0));
            query_bytes_due[query_bytes_due.size() - 1].packet_end = 1'b1;
            name_open = 1'b0;
        end
        if (query_bytes_due.size() > first)
            query_bytes_due[query_bytes_due.size() - 1].run_end = 1'b1;
    endfunction

    always @(posedge clk)
    begin
        query_byte_t got;
        query_byte_t want;
        if (!rst_n)
        begin
            name_open  = 1'b0;
            label_len  = 0;
            label_lost = 1'b0;
            mismatches = 0;
            query_bytes_due.delete();
            pending   <= 0;
        end
        else
        begin
            // output first: a word leaving now never stems from a word taken now
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.data       = m_axis_tdata[7:0];
                got.run_end    = m_axis_tdata[8];
                got.packet_end = m_axis_tlast;
                got.lost       = m_axis_tuser;
                // fields shown as byte, then run end, packet end, overflow
                if (query_bytes_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("byte %0d: unexpected word %02h %0b%0b%0b",
                                 byte_idx, got.data, got.run_end, got.packet_end, got.lost);
                    mismatches++;
                end
                else
                begin
                    want = query_bytes_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display("byte %0d: expected %02h %0b%0b%0b, got %02h %0b%0b%0b",
                                     byte_idx, want.data, want.run_end, want.packet_end,
                                     want.lost, got.data, got.run_end, got.packet_end,
                                     got.lost);
                        mismatches++;
                    end
                end
                byte_idx++;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_query_bytes(s_axis_tdata[7:0], s_axis_tdata[23:8], s_axis_tlast);
            pending <= query_bytes_due.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import dqb_pkg::*;
();

    localparam int LABEL_CAP        = 32;
    localparam int SINK_HOLD_CYCLES = 400;
    // slowest tail of a packet after the sink frees up
    localparam int SETTLE_CYCLES    = 60;

    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // name_char, query_id
    logic        s_axis_tlast;     // name_end

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // out_byte, run_end, zero fill
    logic        m_axis_tlast;     // packet_end
    logic        m_axis_tuser;     // label_overflow

    int          mismatches;
    int          pending;

    // idle odds in percent, per cycle on each side
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    // set by the stimulus; the sink then holds off once
    bit          sink_hold     = 1'b0;
    // set by the sink once its long hold is over
    bit          hold_done     = 1'b0;
    // characters accepted so far
    int          chars_sent    = 0;

    dns_query_builder #(
        .MAX_LABEL (LABEL_CAP)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // watches both channels, predicts every packet byte and counts mismatches
    query_packet_monitor #(
        .MAX_LABEL (LABEL_CAP)
    ) monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // sink side: random back-pressure, plus one long hold on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one character word and wait until the block takes it;
    // each cycle before the offer may idle at the source's odds
    task automatic send_char(input logic [7:0] ch, input logic [15:0] id, input logic name_end);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {id, ch};
        s_axis_tlast  <= name_end;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    // mostly letters, now and then any byte at all (dots and zero included)
    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 80)
            return 8'($urandom_range(122, 97));
        return 8'($urandom);
    endfunction

    // a dotted name of random labels: mostly short, some empty, some past the store size
    task automatic send_random_name();
        logic [7:0] chars[$];
        int         labels;
        int         len;
        int         pick;
        labels = $urandom_range(4, 1);
        for (int l = 0; l < labels; l++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                len = $urandom_range(40, 30);
            else if (pick < 16)
                len = 0;
            else
                len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
                chars.push_back(pick_char());
            if (l < labels - 1)
                chars.push_back(DOT_CHAR);
        end
        // trailing dot marks the root
        if (chars.size() == 0 || $urandom_range(99) < 15)
            chars.push_back(DOT_CHAR);
        foreach (chars[i])
            send_char(chars[i], 16'($urandom), i == chars.size() - 1);
    endtask

    // stop offering and let every predicted byte come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // slow-ish source, very slow sink
        src_idle_pct  = 36;
        sink_idle_pct = 81;

        // zero character alone, lowest id
        send_char(8'h00, 16'h0000, 1'b1);
        // leading dot, double dot, top byte value, trailing dot; highest id
        send_char(DOT_CHAR, 16'hFFFF, 1'b0);
        send_char(DOT_CHAR, 16'h0000, 1'b0);
        send_char(8'hFF, 16'hFFFF, 1'b0);
        send_char(DOT_CHAR, 16'h0000, 1'b1);
        // root only: one dot that also ends the name
        send_char(DOT_CHAR, 16'h8001, 1'b1);
        // plain two-label name, later ids ignored
        send_char(8'h61, 16'h5AA5, 1'b0);
        send_char(8'h62, 16'hFFFF, 1'b0);
        send_char(DOT_CHAR, 16'h0000, 1'b0);
        send_char(8'h63, 16'h1234, 1'b1);
        // odd bytes inside a label
        send_char(8'h7F, 16'h00FF, 1'b0);
        send_char(8'h80, 16'hFF00, 1'b0);
        send_char(8'h01, 16'h0000, 1'b1);

        while (chars_sent < 90)
            send_random_name();
        drain();

        // roles swapped: source mostly idle, sink fast
        src_idle_pct  = 81;
        sink_idle_pct = 36;
        while (chars_sent < 175)
            send_random_name();
        drain();

        // no idling; sink holds off long while a long label keeps coming
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_hold     = 1'b1;
        for (int i = 0; i < 40; i++)
            send_char(8'($urandom_range(122, 97)), 16'($urandom), 1'b0);
        send_char(DOT_CHAR, 16'($urandom), 1'b0);
        send_char(8'h7A, 16'($urandom), 1'b1);
        while (chars_sent < 260)
            send_random_name();
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/dqb_pkg.sv
rtl/dqb_ram.sv
rtl/dqb_ctrl.sv
rtl/dqb_dp.sv
rtl/dns_query_builder.sv
bench/query_packet_monitor.sv
bench/tb_top.sv
